[rtl/core/bfe_pkg.sv]
// ----------------------------------------------------------------------------
// bfe_pkg
// shared constants, types and helpers of the boundary face extractor
// ----------------------------------------------------------------------------
package bfe_pkg;

    localparam int VERTEX_BITS = 16;
    localparam int FACE_SLOTS  = 4096;
    localparam int INDEX_SLOTS = 8192;
    localparam int SLOT_W      = $clog2(FACE_SLOTS);
    localparam int IDX_W       = $clog2(INDEX_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int HASH_W      = IDX_W + 15;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_FACE  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [31:0] HASH_C0 = 32'h9E3779B1;
    localparam logic [31:0] HASH_C1 = 32'h85EBCA77;
    localparam logic [31:0] HASH_C2 = 32'hC2B2AE3D;

    typedef logic [VERTEX_BITS-1:0] vert_t;

    typedef struct packed {
        vert_t high;
        vert_t mid;
        vert_t low;
    } key_t;

    typedef struct packed {
        logic  rep;
        key_t  key;
    } face_word_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } index_word_t;

    typedef struct packed {
        logic start;
        logic done;
    } hash_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FACE_START,
        S_HASH,
        S_IREAD,
        S_IWAIT,
        S_FCHK,
        S_NEXT_FACE,
        S_FETCH,
        S_FWAIT,
        S_RESP
    } state_t;

    function automatic key_t sort3(vert_t a, vert_t b, vert_t c);
        vert_t x;
        vert_t y;
        vert_t z;
        vert_t t;
        key_t  k;
        x = a;
        y = b;
        z = c;
        if (x > y)
        begin
            t = x; x = y; y = t;
        end
        if (y > z)
        begin
            t = y; y = z; z = t;
        end
        if (x > y)
        begin
            t = x; x = y; y = t;
        end
        k.low  = x;
        k.mid  = y;
        k.high = z;
        return k;
    endfunction

endpackage

[rtl/core/bfe_ram.sv]
// ----------------------------------------------------------------------------
// bfe_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module bfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/bfe_hash.sv]
// ----------------------------------------------------------------------------
// bfe_hash
// face key hash, one shared multiplier over the three key vertices
// ----------------------------------------------------------------------------
module bfe_hash
    import bfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  hash_ctl_t        ctl_in,
    input  key_t             key,
    output hash_ctl_t        ctl_out,
    output logic [IDX_W-1:0] pos
);

    logic [1:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] acc_next;
    logic [HASH_W-1:0] mul;
    vert_t             operand;
    logic [HASH_W-1:0] coef;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                operand = key.low;
                coef    = HASH_C0[HASH_W-1:0];
            end
            2'd1:
            begin
                operand = key.mid;
                coef    = HASH_C1[HASH_W-1:0];
            end
            default:
            begin
                operand = key.high;
                coef    = HASH_C2[HASH_W-1:0];
            end
        endcase
        mul      = HASH_W'(HASH_W'(operand) * coef);
        acc_next = ((step_reg == 2'd0) ? '0 : acc_reg) ^ mul;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= '0;
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !ctl_in.start)
        begin
            acc_reg <= acc_next;
        end
    end

    assign pos           = acc_reg[IDX_W-1:0] ^ acc_reg[HASH_W-1:15];
    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = done_reg;

endmodule

[rtl/core/boundary_face_extractor.sv]
// ----------------------------------------------------------------------------
// boundary_face_extractor
// face table of a tetrahedral mesh, returns faces seen exactly once
// ----------------------------------------------------------------------------
// add: per face hash the key, then probe the index ram and, for a live slot, check
// the face ram for a known face; fetch: read the face ram, skipping repeated faces
// clear: sweeps the index ram; one item at a time, no new item until the last is through
// after reset the index ram is swept, one entry a cycle, s_tready low
module boundary_face_extractor
    import bfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // vert_0, vert_1, vert_2, vert_3
    input  logic [2:0]  s_tuser,   // opcode[1:0], keep
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // face_low, face_mid, face_high
    output logic [1:0]  m_tuser    // status
);

    state_t            state_reg, state_next;
    vert_t             v_reg [4];
    logic [1:0]        fidx_reg, fidx_next;
    key_t              key_reg, key_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  probes_reg, probes_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic              clr_resp_reg, clr_resp_next;
    logic              drop_reg, drop_next;
    logic [1:0]        rstat_reg, rstat_next;
    key_t              rkey_reg, rkey_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_stat_reg, out_stat_next;
    key_t              out_key_reg, out_key_next;

    logic              accept;
    logic [1:0]        in_op;
    logic              in_keep;
    logic              probe_last;
    logic              slot_live;
    logic              out_free;
    key_t              face_key;

    hash_ctl_t         hctl_in, hctl_out;
    logic [IDX_W-1:0]  hash_pos;

    logic              i_we, i_re;
    logic [IDX_W-1:0]  i_waddr, i_raddr;
    index_word_t       i_wdata, i_rdata;
    logic              f_we, f_re;
    logic [SLOT_W-1:0] f_waddr, f_raddr;
    face_word_t        f_wdata, f_rdata;

    bfe_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (hctl_in),
        .key     (key_reg),
        .ctl_out (hctl_out),
        .pos     (hash_pos)
    );

    bfe_ram #(.WIDTH($bits(index_word_t)), .DEPTH(INDEX_SLOTS)) u_index_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .re    (i_re),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    bfe_ram #(.WIDTH($bits(face_word_t)), .DEPTH(FACE_SLOTS)) u_face_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    assign in_op      = s_tuser[1:0];
    assign in_keep    = s_tuser[2];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign probe_last = (probes_reg == IDX_W'(INDEX_SLOTS - 1));
    assign slot_live  = (CNT_W'(i_rdata.slot) < total_reg);
    assign out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        case (fidx_reg)
            2'd0:    face_key = sort3(v_reg[1], v_reg[2], v_reg[3]);
            2'd1:    face_key = sort3(v_reg[0], v_reg[2], v_reg[3]);
            2'd2:    face_key = sort3(v_reg[0], v_reg[1], v_reg[3]);
            default: face_key = sort3(v_reg[0], v_reg[1], v_reg[2]);
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_ADD && in_keep)
                    begin
                        state_next = S_FACE_START;
                    end
                    else if (in_op == OP_FETCH)
                    begin
                        state_next = S_FETCH;
                    end
                    else if (in_op == OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_CLEAR:
            begin
                if (clr_reg == IDX_W'(INDEX_SLOTS - 1))
                begin
                    state_next = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_FACE_START:
            begin
                state_next = S_HASH;
            end
            S_HASH:
            begin
                if (hctl_out.done)
                begin
                    state_next = S_IREAD;
                end
            end
            S_IREAD:
            begin
                state_next = S_IWAIT;
            end
            S_IWAIT:
            begin
                if (!i_rdata.valid)
                begin
                    state_next = S_NEXT_FACE;
                end
                else if (slot_live)
                begin
                    state_next = S_FCHK;
                end
                else
                begin
                    state_next = probe_last ? S_NEXT_FACE : S_IREAD;
                end
            end
            S_FCHK:
            begin
                if (f_rdata.key == key_reg || probe_last)
                begin
                    state_next = S_NEXT_FACE;
                end
                else
                begin
                    state_next = S_IREAD;
                end
            end
            S_NEXT_FACE:
            begin
                state_next = (fidx_reg == 2'd3) ? S_RESP : S_FACE_START;
            end
            S_FETCH:
            begin
                state_next = (cursor_reg < total_reg) ? S_FWAIT : S_RESP;
            end
            S_FWAIT:
            begin
                state_next = f_rdata.rep ? S_FETCH : S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        fidx_next      = fidx_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        probes_next    = probes_reg;
        slot_next      = slot_reg;
        total_next     = total_reg;
        cursor_next    = cursor_reg;
        clr_next       = clr_reg;
        clr_resp_next  = clr_resp_reg;
        drop_next      = drop_reg;
        rstat_next     = rstat_reg;
        rkey_next      = rkey_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_stat_next  = out_stat_reg;
        out_key_next   = out_key_reg;
        hctl_in.start  = 1'b0;
        hctl_in.done   = 1'b0;
        i_we           = 1'b0;
        i_waddr        = pos_reg;
        i_wdata        = '0;
        i_re           = 1'b0;
        i_raddr        = pos_reg;
        f_we           = 1'b0;
        f_waddr        = total_reg[SLOT_W-1:0];
        f_wdata        = '0;
        f_re           = 1'b0;
        f_raddr        = cursor_reg[SLOT_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fidx_next     = '0;
                    drop_next     = 1'b0;
                    rstat_next    = ST_DONE;
                    rkey_next     = '0;
                    clr_next      = '0;
                    clr_resp_next = 1'b1;
                end
            end
            S_CLEAR:
            begin
                i_we     = 1'b1;
                i_waddr  = clr_reg;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(INDEX_SLOTS - 1))
                begin
                    total_next  = '0;
                    cursor_next = '0;
                end
            end
            S_FACE_START:
            begin
                key_next      = face_key;
                hctl_in.start = 1'b1;
            end
            S_HASH:
            begin
                pos_next    = hash_pos;
                probes_next = '0;
            end
            S_IREAD:
            begin
                i_re = 1'b1;
            end
            S_IWAIT:
            begin
                slot_next = i_rdata.slot;
                if (!i_rdata.valid)
                begin
                    if (total_reg >= CNT_W'(FACE_SLOTS))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        f_we          = 1'b1;
                        f_wdata.key   = key_reg;
                        f_wdata.rep   = 1'b0;
                        i_we          = 1'b1;
                        i_wdata.valid = 1'b1;
                        i_wdata.slot  = total_reg[SLOT_W-1:0];
                        total_next    = total_reg + CNT_W'(1);
                    end
                end
                else if (slot_live)
                begin
                    f_re    = 1'b1;
                    f_raddr = i_rdata.slot;
                end
                else
                begin
                    pos_next    = pos_reg + IDX_W'(1);
                    probes_next = probes_reg + IDX_W'(1);
                    if (probe_last)
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            S_FCHK:
            begin
                if (f_rdata.key == key_reg)
                begin
                    f_we        = 1'b1;
                    f_waddr     = slot_reg;
                    f_wdata.key = key_reg;
                    f_wdata.rep = 1'b1;
                end
                else
                begin
                    pos_next    = pos_reg + IDX_W'(1);
                    probes_next = probes_reg + IDX_W'(1);
                    if (probe_last)
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            S_NEXT_FACE:
            begin
                fidx_next  = fidx_reg + 2'd1;
                rstat_next = drop_reg ? ST_FULL : ST_DONE;
            end
            S_FETCH:
            begin
                if (cursor_reg < total_reg)
                begin
                    f_re = 1'b1;
                end
                else
                begin
                    rstat_next = ST_EMPTY;
                end
            end
            S_FWAIT:
            begin
                cursor_next = cursor_reg + CNT_W'(1);
                if (!f_rdata.rep)
                begin
                    rstat_next = ST_FACE;
                    rkey_next  = f_rdata.key;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = rstat_reg;
                    out_key_next   = rkey_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clr_resp_reg  <= 1'b0;
            total_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_resp_reg  <= clr_resp_next;
            total_reg     <= total_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg[0] <= s_tdata[15:0];
            v_reg[1] <= s_tdata[31:16];
            v_reg[2] <= s_tdata[47:32];
            v_reg[3] <= s_tdata[63:48];
        end
        fidx_reg     <= fidx_next;
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        probes_reg   <= probes_next;
        slot_reg     <= slot_next;
        drop_reg     <= drop_next;
        rstat_reg    <= rstat_next;
        rkey_reg     <= rkey_next;
        out_stat_reg <= out_stat_next;
        out_key_reg  <= out_key_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_key_reg;
    assign m_tuser  = out_stat_reg;

endmodule

[verif/bfe_checker.sv]
// ----------------------------------------------------------------------------
// bfe_checker
// watches both streams of the boundary face extractor, predicts each answer
// from its own face table and compares the answers field by field
// ----------------------------------------------------------------------------
module bfe_checker
    import bfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // vert_0, vert_1, vert_2, vert_3
    input  logic [2:0]  s_tuser,   // opcode[1:0], keep
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // face_low, face_mid, face_high
    input  logic [1:0]  m_tuser,   // status
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0] status;
        vert_t      high;
        vert_t      mid;
        vert_t      low;
    } answer_t;

    key_t              known_keys [FACE_SLOTS];
    logic              known_rep  [FACE_SLOTS];
    logic              slot_used  [INDEX_SLOTS];
    logic [SLOT_W-1:0] slot_of    [INDEX_SLOTS];
    int unsigned       face_count;
    int unsigned       read_pos;
    answer_t           expected_answers[$];

    function automatic key_t order_face(vert_t a, vert_t b, vert_t c);
        vert_t lo;
        vert_t hi;
        key_t  k;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo)
        begin
            k.low = c; k.mid = lo; k.high = hi;
        end
        else if (c < hi)
        begin
            k.low = lo; k.mid = c; k.high = hi;
        end
        else
        begin
            k.low = lo; k.mid = hi; k.high = c;
        end
        return k;
    endfunction

    function automatic int unsigned face_hash(key_t k);
        logic [31:0] h;
        h = (32'(k.low) * HASH_C0) ^ (32'(k.mid) * HASH_C1) ^ (32'(k.high) * HASH_C2);
        h = h ^ (h >> 15);
        return h % INDEX_SLOTS;
    endfunction

    // returns 1 when the face is dropped for lack of room
    function automatic logic record_face(key_t k);
        int unsigned pos;
        pos = face_hash(k);
        for (int n = 0; n < INDEX_SLOTS; n++)
        begin
            if (!slot_used[pos])
            begin
                if (face_count >= FACE_SLOTS)
                    return 1'b1;
                known_keys[face_count] = k;
                known_rep[face_count]  = 1'b0;
                slot_used[pos]         = 1'b1;
                slot_of[pos]           = face_count[SLOT_W-1:0];
                face_count++;
                return 1'b0;
            end
            else if (slot_of[pos] < face_count && known_keys[slot_of[pos]] == k)
            begin
                known_rep[slot_of[pos]] = 1'b1;
                return 1'b0;
            end
            pos = (pos + 1) % INDEX_SLOTS;
        end
        return 1'b1;
    endfunction

    function automatic answer_t predict_answer(logic [2:0] user, logic [63:0] data);
        answer_t a;
        vert_t   v0;
        vert_t   v1;
        vert_t   v2;
        vert_t   v3;
        logic    lost;
        a    = '0;
        a.status = ST_DONE;
        v0   = data[15:0];
        v1   = data[31:16];
        v2   = data[47:32];
        v3   = data[63:48];
        lost = 1'b0;
        case (user[1:0])
            OP_ADD:
                if (user[2])
                begin
                    lost |= record_face(order_face(v1, v2, v3));
                    lost |= record_face(order_face(v0, v2, v3));
                    lost |= record_face(order_face(v0, v1, v3));
                    lost |= record_face(order_face(v0, v1, v2));
                    if (lost)
                        a.status = ST_FULL;
                end
            OP_FETCH:
            begin
                a.status = ST_EMPTY;
                while (read_pos < face_count)
                begin
                    read_pos++;
                    if (!known_rep[read_pos-1])
                    begin
                        a.status = ST_FACE;
                        a.low    = known_keys[read_pos-1].low;
                        a.mid    = known_keys[read_pos-1].mid;
                        a.high   = known_keys[read_pos-1].high;
                        break;
                    end
                end
            end
            OP_CLEAR:
            begin
                foreach (slot_used[i])
                    slot_used[i] = 1'b0;
                face_count = 0;
                read_pos   = 0;
            end
            default: ;
        endcase
        return a;
    endfunction

    assign pending = expected_answers.size();

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            face_count = 0;
            read_pos   = 0;
            fail_count = 0;
            expected_answers.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[47:32], m_tdata[31:16], m_tdata[15:0]};
                if (expected_answers.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: status %0d faces %0h %0h %0h",
                                 got.status, got.low, got.mid, got.high);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %0d %0h %0h %0h, got %0d %0h %0h %0h",
                                     want.status, want.low, want.mid, want.high,
                                     got.status, got.low, got.mid, got.high);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_answers.push_back(predict_answer(s_tuser, s_tdata));
        end
    end

endmodule

[verif/tb_boundary_face_extractor.sv]
// ----------------------------------------------------------------------------
// tb_boundary_face_extractor
// drives adds, fetches, clears and unused opcodes with random stalls on both streams;
// the checker beside the block predicts and compares every answer
// ----------------------------------------------------------------------------
module tb_boundary_face_extractor;
    import bfe_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // vert_0, vert_1, vert_2, vert_3
    logic [2:0]  s_tuser;    // opcode[1:0], keep
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // face_low, face_mid, face_high
    logic [1:0]  m_tuser;    // status
    int          fail_count;
    int          pending;
    int          send_gap;
    int          take_gap;
    vert_t       last_tet [4];

    boundary_face_extractor DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    bfe_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= take_gap);

    task automatic send_word(logic [1:0] op, vert_t v0, vert_t v1, vert_t v2, vert_t v3,
                             logic keep);
        @(negedge clk);
        while ($urandom_range(99) < send_gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {v3, v2, v1, v0};
        s_tuser  <= {keep, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_tet(vert_t v0, vert_t v1, vert_t v2, vert_t v3);
        last_tet = '{v0, v1, v2, v3};
        send_word(OP_ADD, v0, v1, v2, v3, 1'b1);
    endtask

    task automatic send_random_word();
        int    pick;
        vert_t nv [4];
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            case ($urandom_range(9))
                0, 1:
                    foreach (nv[i])
                        nv[i] = 16'($urandom);
                2, 3, 4:
                    foreach (nv[i])
                        nv[i] = 16'($urandom_range(15));
                default:
                begin
                    // neighbor sharing a face with the previous tetrahedron
                    nv = last_tet;
                    nv[$urandom_range(3)] = 16'($urandom_range(31));
                end
            endcase
            if ($urandom_range(9) == 0)
                send_word(OP_ADD, nv[0], nv[1], nv[2], nv[3], 1'b0);
            else
                send_tet(nv[0], nv[1], nv[2], nv[3]);
        end
        else if (pick < 92)
            send_word(OP_FETCH, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom));
        else if (pick < 94)
            send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom));
        else
            send_word(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        send_gap = 10;
        take_gap = 59;
        last_tet = '{16'd0, 16'd1, 16'd2, 16'd3};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(OP_FETCH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_tet(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF);
        send_tet(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tet(16'd5, 16'd5, 16'd6, 16'd7);
        send_word(OP_ADD, 16'hAAAA, 16'h5555, 16'h1234, 16'hFEDC, 1'b0);
        send_tet(16'd1, 16'd2, 16'd3, 16'd4);
        send_tet(16'd4, 16'd3, 16'd2, 16'd9);
        send_tet(16'd1, 16'd2, 16'd3, 16'd4);
        repeat (3) send_word(OP_FETCH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_tet(16'h0000, 16'hFFFF, 16'h8000, 16'h1111);
        repeat (6) send_word(OP_FETCH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(OP_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_word(OP_FETCH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_tet(16'd1, 16'd2, 16'd3, 16'd4);
        send_word(OP_FETCH, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);

        repeat (260) send_random_word();
        send_gap = 59;
        take_gap = 10;
        repeat (260) send_random_word();
        send_gap = 0;
        take_gap = 0;
        repeat (257) send_random_word();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
